>>> hdl/htsed_pkg.sv
// ----------------------------------------------------------------------------
// htsed_pkg: shared types, codes and tables for the HTML tag stripper
// Holds the payload structs, controller commands and the entity table.
// ----------------------------------------------------------------------------
package htsed_pkg;

  // Payload of one input transaction.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_end;
  } in_item_t;

  // Payload of one result transaction.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_end;
  } out_item_t;

  localparam logic [15:0] CAP_RESET = 16'd4096;

  // Lookahead kinds.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TAG  = 2'd1;
  localparam logic [1:0] KIND_ENT  = 2'd2;

  // Datapath operations issued by the controller.
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_ITEM   = 3'd2;
  localparam logic [2:0] OP_REPLAY = 3'd3;
  localparam logic [2:0] OP_PLAIN  = 3'd4;
  localparam logic [2:0] OP_TERM   = 3'd5;

  // Entity match outcomes.
  localparam logic [1:0] ENT_NONE   = 2'd0;
  localparam logic [1:0] ENT_PREFIX = 2'd1;
  localparam logic [1:0] ENT_FULL   = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic [2:0] op;
    logic [2:0] idx;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       item_end;
    logic       ent_pending;
    logic       ent_mismatch;
    logic [2:0] fill;
    logic       out_free;
  } status_t;

  typedef struct packed {
    logic [1:0] code;
    logic [7:0] value;
  } ent_res_t;

  // Entity names without the leading ampersand, padded with zeros.
  localparam logic [0:4][0:4][7:0] ENT_TEXT = '{
    '{"l", "t", ";", 8'h00, 8'h00},
    '{"g", "t", ";", 8'h00, 8'h00},
    '{"a", "m", "p", ";", 8'h00},
    '{"q", "u", "o", "t", ";"},
    '{"n", "b", "s", "p", ";"}
  };
  localparam logic [0:4][2:0] ENT_LEN = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5};
  localparam logic [0:4][7:0] ENT_VAL = '{"<", ">", "&", "\"", " "};

  // Compare the buffered bytes plus the new byte against every entity.
  // First letters are all distinct, so at most one entity can hit.
  function automatic ent_res_t ent_match(logic [3:0][7:0] la, logic [2:0] fill,
                                         logic [7:0] b);
    ent_res_t         r;
    logic [0:4][7:0]  cand;
    logic [2:0]       n;
    logic             hit;
    n = fill + 3'd1;
    for (int i = 0; i < 5; i++) begin
      if (3'(i) < fill) begin
        cand[i] = la[2'(i)];
      end else if (3'(i) == fill) begin
        cand[i] = b;
      end else begin
        cand[i] = 8'h00;
      end
    end
    r.code  = ENT_NONE;
    r.value = 8'h00;
    for (int e = 0; e < 5; e++) begin
      hit = (ENT_LEN[e] >= n);
      for (int i = 0; i < 5; i++) begin
        if ((3'(i) < n) && (ENT_TEXT[e][i] != cand[i])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        if (ENT_LEN[e] == n) begin
          r.code  = ENT_FULL;
          r.value = ENT_VAL[e];
        end else begin
          r.code = ENT_PREFIX;
        end
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/html_tag_strip_entity_decode_core.sv
// ----------------------------------------------------------------------------
// html_tag_strip_entity_decode_core: HTML tag stripper with entity decoding
// An item is accepted and then evaluated; an entity that breaks replays the
// ampersand and each buffered byte before the byte itself, and an end item
// emits the terminator, after replaying an open entity. Output stalls hold it.
// Synchronous reset clears all string state and loads the capacity register
// with 4096; no clearing pass.
// ----------------------------------------------------------------------------
module html_tag_strip_entity_decode_core
  import htsed_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  htsed_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // State and output datapath.
  htsed_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> hdl/htsed_ctrl.sv
// ----------------------------------------------------------------------------
// htsed_ctrl: sequencing state machine
// Accepts one item, then walks the datapath through evaluation, the replay
// of a broken entity and the final plain byte or terminator.
// ----------------------------------------------------------------------------
module htsed_ctrl
  import htsed_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EVAL   = 2'd1;
  localparam logic [1:0] ST_REPLAY = 2'd2;
  localparam logic [1:0] ST_FINAL  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;

  // New transactions are taken only between items.
  assign in_stall = (state_r != ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd.op    = OP_NONE;
    cmd.idx   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.item_end) begin
          idx_nxt   = 3'd0;
          state_nxt = status.ent_pending ? ST_REPLAY : ST_FINAL;
        end else if (status.ent_mismatch) begin
          idx_nxt   = 3'd0;
          state_nxt = ST_REPLAY;
        end else if (status.out_free) begin
          cmd.op    = OP_ITEM;
          state_nxt = ST_IDLE;
        end
      end
      ST_REPLAY: begin
        // One buffered byte per cycle while the output is free: the ampersand first, then the letters.
        if (status.out_free) begin
          cmd.op = OP_REPLAY;
          if (idx_r == status.fill) begin
            idx_nxt   = 3'd0;
            state_nxt = ST_FINAL;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      ST_FINAL: begin
        if (status.out_free) begin
          cmd.op    = status.item_end ? OP_TERM : OP_PLAIN;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

>>> hdl/htsed_dp.sv
// ----------------------------------------------------------------------------
// htsed_dp: string state, lookahead buffer and output register
// Carries out one controller operation per cycle and reports status back.
// ----------------------------------------------------------------------------
module htsed_dp
  import htsed_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      cfg_we,
  input  logic [15:0] cfg_wdata,
  input  cmd_t      cmd,
  output status_t   status,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [15:0]     cap_r;
  in_item_t        item_r, item_nxt;
  logic            inside_r, inside_nxt;
  logic [15:0]     wc_r, wc_nxt;
  logic [7:0]      last_r, last_nxt;
  logic [3:0][7:0] la_r, la_nxt;
  logic [2:0]      fill_r, fill_nxt;
  logic [1:0]      kind_r, kind_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic [7:0]  b;
  logic        full;
  logic        nl_ok;
  logic        out_free;
  logic        emit_req;
  logic [7:0]  emit_val;
  logic        do_plain;
  logic        buffered;
  logic        tag_hit;
  logic [1:0]  rep_sel;
  ent_res_t    match;

  assign b        = item_r.in_byte;
  assign full     = ({1'b0, wc_r} + 17'd1) >= {1'b0, cap_r};
  assign nl_ok    = (wc_r != 16'd0) && (last_r != 8'h0A) &&
                    (({1'b0, wc_r} + 17'd2) < {1'b0, cap_r});
  assign out_free = !out_valid_r || !out_stall;
  assign match    = ent_match(la_r, fill_r, b);
  assign rep_sel  = 2'(cmd.idx - 3'd1);

  // A tag name opening with br or /p, seen at its second letter.
  assign tag_hit = (((la_r[0] == "b") || (la_r[0] == "B")) && ((b == "r") || (b == "R"))) ||
                   ((la_r[0] == "/") && ((b == "p") || (b == "P")));

  // Status for the controller.
  assign status.item_end     = item_r.in_end;
  assign status.ent_pending  = (kind_r == KIND_ENT);
  assign status.ent_mismatch = !item_r.in_end && (kind_r == KIND_ENT) && !full &&
                               (match.code == ENT_NONE);
  assign status.fill         = fill_r;
  assign status.out_free     = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Operation decode.
  always_comb begin
    item_nxt      = item_r;
    inside_nxt    = inside_r;
    wc_nxt        = wc_r;
    last_nxt      = last_r;
    la_nxt        = la_r;
    fill_nxt      = fill_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    emit_req      = 1'b0;
    emit_val      = b;
    do_plain      = 1'b0;
    buffered      = 1'b0;

    case (cmd.op)
      OP_LOAD: begin
        item_nxt = in_data;
      end
      OP_ITEM: begin
        if (!full) begin
          if (kind_r == KIND_TAG) begin
            // First letters of a tag name decide on a line break.
            if (fill_r == 3'd0) begin
              if ((b == "p") || (b == "P")) begin
                emit_req = nl_ok;
                emit_val = 8'h0A;
              end else if ((b == "b") || (b == "B") || (b == "/")) begin
                la_nxt[0] = b;
                fill_nxt  = 3'd1;
                buffered  = 1'b1;
              end
            end else if (tag_hit) begin
              emit_req = nl_ok;
              emit_val = 8'h0A;
            end
            if (!buffered) begin
              kind_nxt = KIND_NONE;
              fill_nxt = 3'd0;
              if (b == ">") begin
                inside_nxt = 1'b0;
              end
            end
          end else if (kind_r == KIND_ENT) begin
            // Entity still matching or complete; a mismatch is replayed.
            case (match.code)
              ENT_PREFIX: begin
                la_nxt[fill_r[1:0]] = b;
                fill_nxt            = fill_r + 3'd1;
              end
              ENT_FULL: begin
                kind_nxt = KIND_NONE;
                fill_nxt = 3'd0;
                emit_req = 1'b1;
                emit_val = match.value;
              end
              default: begin
              end
            endcase
          end else begin
            do_plain = 1'b1;
          end
        end
      end
      OP_REPLAY: begin
        emit_req = 1'b1;
        emit_val = (cmd.idx == 3'd0) ? "&" : la_r[rep_sel];
      end
      OP_PLAIN: begin
        kind_nxt = KIND_NONE;
        fill_nxt = 3'd0;
        do_plain = 1'b1;
      end
      OP_TERM: begin
        if (cap_r != 16'd0) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.out_byte = 8'h00;
          out_data_nxt.out_end  = 1'b1;
        end
        inside_nxt = 1'b0;
        wc_nxt     = 16'd0;
        last_nxt   = 8'h00;
        fill_nxt   = 3'd0;
        kind_nxt   = KIND_NONE;
      end
      default: begin
      end
    endcase

    // Ordinary text byte handling.
    if (do_plain && !full) begin
      if (inside_r) begin
        if (b == ">") begin
          inside_nxt = 1'b0;
        end
      end else if (b == "<") begin
        inside_nxt = 1'b1;
        kind_nxt   = KIND_TAG;
        fill_nxt   = 3'd0;
      end else if (b == "&") begin
        kind_nxt = KIND_ENT;
        fill_nxt = 3'd0;
      end else if (b != 8'h0D) begin
        emit_req = 1'b1;
        emit_val = (b == 8'h09) ? " " : b;
      end
    end

    // Single text emission, refused once the buffer is full.
    if (emit_req && !full) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.out_byte = emit_val;
      out_data_nxt.out_end  = 1'b0;
      wc_nxt                = wc_r + 16'd1;
      last_nxt              = emit_val;
    end
  end

  // Control and string state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      inside_r    <= 1'b0;
      wc_r        <= 16'd0;
      last_r      <= 8'h00;
      fill_r      <= 3'd0;
      kind_r      <= KIND_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      inside_r    <= inside_nxt;
      wc_r        <= wc_nxt;
      last_r      <= last_nxt;
      fill_r      <= fill_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    la_r       <= la_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
